// ----- hdl/qrv_pkg.sv -----
// Shared constants for the quaternion vector rotation unit.
package qrv_pkg;

    localparam int QRV_VEC_WIDTH  = 32;
    localparam int QRV_QUAT_WIDTH = 16;

endpackage

// ----- hdl/quaternion_rotate_vector_unit.sv -----
// Pipelined rotation of a fixed-point 3-vector by a quaternion or its inverse.
//
//  channel | signals                                   | word contents
//  --------+-------------------------------------------+--------------------------------
//  in      | in_valid, in_stall                        | cmd, quat_x/y/z/w, vec_x/y/z
//  out     | out_valid, out_stall                      | out_x, out_y, out_z
//
// Four register stages: products, dot/cross sums, second products, sum and saturate.
// One word enters per cycle while the pipeline flows.
// Each stage holds its word while the next one is full and stalled, so empty
// stages fill up behind a stalled output and nothing is dropped or repeated.
// rst_n clears the stage valid bits only.
module quaternion_rotate_vector_unit #(
    parameter int VEC_WIDTH  = qrv_pkg::QRV_VEC_WIDTH,
    parameter int QUAT_WIDTH = qrv_pkg::QRV_QUAT_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         cmd,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    input  logic signed [VEC_WIDTH-1:0]  vec_x,
    input  logic signed [VEC_WIDTH-1:0]  vec_y,
    input  logic signed [VEC_WIDTH-1:0]  vec_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [VEC_WIDTH-1:0]  out_x,
    output logic signed [VEC_WIDTH-1:0]  out_y,
    output logic signed [VEC_WIDTH-1:0]  out_z
);

    localparam int F    = QUAT_WIDTH - 1;
    localparam int V2W  = VEC_WIDTH + 1;
    localparam int P1W  = QUAT_WIDTH + V2W;
    localparam int RW1  = P1W - F;
    localparam int DW   = VEC_WIDTH + 4;
    localparam int CW   = VEC_WIDTH + 3;
    localparam int QSW  = 2 * QUAT_WIDTH;
    localparam int CPW  = CW + QUAT_WIDTH;
    localparam int CRW  = CPW - F;
    localparam int TPW  = V2W + QSW;
    localparam int T1W  = TPW - 2 * F;
    localparam int DPW  = DW + QUAT_WIDTH;
    localparam int T3W  = DPW - F;
    localparam int SW   = VEC_WIDTH + 7;

    localparam logic signed [P1W-1:0] RND1  = P1W'(1) << (F - 1);
    localparam logic signed [QSW-1:0] HALF2 = QSW'(1) << (2 * F - 1);
    localparam logic signed [CPW-1:0] RNDC  = CPW'(1) << (F - 1);
    localparam logic signed [TPW-1:0] RNDT  = TPW'(1) << (2 * F - 1);
    localparam logic signed [DPW-1:0] RNDD  = DPW'(1) << (F - 1);

    // handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !s4_valid_reg || !out_stall;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_stall = !rdy1;

    // stage 1: first products
    logic signed [QUAT_WIDTH-1:0] q_in  [3];
    logic signed [VEC_WIDTH-1:0]  v_in  [3];
    logic signed [RW1-1:0]        dp_next [3];
    logic signed [RW1-1:0]        xa_next [3];
    logic signed [RW1-1:0]        xb_next [3];
    logic signed [QSW-1:0]        qwsq_next;

    assign q_in[0] = quat_x;
    assign q_in[1] = quat_y;
    assign q_in[2] = quat_z;
    assign v_in[0] = vec_x;
    assign v_in[1] = vec_y;
    assign v_in[2] = vec_z;
    assign qwsq_next = quat_w * quat_w;

    for (genvar g = 0; g < 3; g++) begin : g_s1
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        logic signed [V2W-1:0] v2_j, v2_k, v2_g;
        logic signed [P1W-1:0] dp_p, xa_p, xb_p;
        assign v2_g = $signed({v_in[g], 1'b0});
        assign v2_j = $signed({v_in[J], 1'b0});
        assign v2_k = $signed({v_in[K], 1'b0});
        assign dp_p = q_in[g] * v2_g + RND1;
        assign xa_p = q_in[J] * v2_k + RND1;
        assign xb_p = q_in[K] * v2_j + RND1;
        assign dp_next[g] = dp_p[P1W-1:F];
        assign xa_next[g] = xa_p[P1W-1:F];
        assign xb_next[g] = xb_p[P1W-1:F];
    end

    logic signed [RW1-1:0]        dp_reg [3];
    logic signed [RW1-1:0]        xa_reg [3];
    logic signed [RW1-1:0]        xb_reg [3];
    logic signed [QSW-1:0]        qwsq_reg;
    logic signed [QUAT_WIDTH-1:0] q_s1_reg [3];
    logic signed [QUAT_WIDTH-1:0] qw_s1_reg;
    logic signed [VEC_WIDTH-1:0]  v_s1_reg [3];
    logic                         inv_s1_reg;

    // stage 2: dot product, cross product, qw^2 - 1/2
    logic signed [DW-1:0]  dot2_next;
    logic signed [CW-1:0]  c_next [3];
    logic signed [QSW-1:0] qw2_next;

    assign dot2_next = DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]);
    assign qw2_next  = qwsq_reg - HALF2;

    for (genvar g = 0; g < 3; g++) begin : g_s2
        assign c_next[g] = CW'(xa_reg[g]) - CW'(xb_reg[g]);
    end

    logic signed [DW-1:0]         dot2_reg;
    logic signed [CW-1:0]         c_reg [3];
    logic signed [QSW-1:0]        qw2_reg;
    logic signed [QUAT_WIDTH-1:0] q_s2_reg [3];
    logic signed [QUAT_WIDTH-1:0] qw_s2_reg;
    logic signed [VEC_WIDTH-1:0]  v_s2_reg [3];
    logic                         inv_s2_reg;

    // stage 3: second products
    logic signed [CRW-1:0] cr_next [3];
    logic signed [T1W-1:0] t1_next [3];
    logic signed [T3W-1:0] t3_next [3];

    for (genvar g = 0; g < 3; g++) begin : g_s3
        logic signed [V2W-1:0] v2;
        logic signed [CPW-1:0] cr_p;
        logic signed [TPW-1:0] t1_p;
        logic signed [DPW-1:0] t3_p;
        assign v2   = $signed({v_s2_reg[g], 1'b0});
        assign cr_p = c_reg[g] * qw_s2_reg + RNDC;
        assign t1_p = v2 * qw2_reg + RNDT;
        assign t3_p = q_s2_reg[g] * dot2_reg + RNDD;
        assign cr_next[g] = cr_p[CPW-1:F];
        assign t1_next[g] = t1_p[TPW-1:2*F];
        assign t3_next[g] = t3_p[DPW-1:F];
    end

    logic signed [CRW-1:0] cr_reg [3];
    logic signed [T1W-1:0] t1_reg [3];
    logic signed [T3W-1:0] t3_reg [3];
    logic                  inv_s3_reg;

    // stage 4: sum and saturate
    logic signed [VEC_WIDTH-1:0] res_next [3];

    for (genvar g = 0; g < 3; g++) begin : g_s4
        logic signed [SW-1:0] sum;
        logic                 fits;
        assign sum  = inv_s3_reg ? SW'(t1_reg[g]) - SW'(cr_reg[g]) + SW'(t3_reg[g])
                                 : SW'(t1_reg[g]) + SW'(cr_reg[g]) + SW'(t3_reg[g]);
        assign fits = (&sum[SW-1:VEC_WIDTH-1]) || !(|sum[SW-1:VEC_WIDTH-1]);
        assign res_next[g] = fits ? sum[VEC_WIDTH-1:0]
                                  : {sum[SW-1], {(VEC_WIDTH-1){~sum[SW-1]}}};
    end

    logic signed [VEC_WIDTH-1:0] out_x_reg, out_y_reg, out_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i]   <= dp_next[i];
                xa_reg[i]   <= xa_next[i];
                xb_reg[i]   <= xb_next[i];
                q_s1_reg[i] <= q_in[i];
                v_s1_reg[i] <= v_in[i];
            end
            qwsq_reg   <= qwsq_next;
            qw_s1_reg  <= quat_w;
            inv_s1_reg <= cmd;
        end
        if (rdy2 && s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i]    <= c_next[i];
                q_s2_reg[i] <= q_s1_reg[i];
                v_s2_reg[i] <= v_s1_reg[i];
            end
            dot2_reg   <= dot2_next;
            qw2_reg    <= qw2_next;
            qw_s2_reg  <= qw_s1_reg;
            inv_s2_reg <= inv_s1_reg;
        end
        if (rdy3 && s2_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= cr_next[i];
                t1_reg[i] <= t1_next[i];
                t3_reg[i] <= t3_next[i];
            end
            inv_s3_reg <= inv_s2_reg;
        end
        if (rdy4 && s3_valid_reg)
        begin
            out_x_reg <= res_next[0];
            out_y_reg <= res_next[1];
            out_z_reg <= res_next[2];
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

endmodule

// ----- dv/quaternion_rotate_vector_checker.sv -----
// Scoreboard for the quaternion vector rotation unit: predicts each word and compares.
`timescale 1ns / 1ps

module quaternion_rotate_vector_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic                                      in_stall,
    input  logic                                      cmd,
    input  logic signed [qrv_pkg::QRV_QUAT_WIDTH-1:0] quat_x,
    input  logic signed [qrv_pkg::QRV_QUAT_WIDTH-1:0] quat_y,
    input  logic signed [qrv_pkg::QRV_QUAT_WIDTH-1:0] quat_z,
    input  logic signed [qrv_pkg::QRV_QUAT_WIDTH-1:0] quat_w,
    input  logic signed [qrv_pkg::QRV_VEC_WIDTH-1:0]  vec_x,
    input  logic signed [qrv_pkg::QRV_VEC_WIDTH-1:0]  vec_y,
    input  logic signed [qrv_pkg::QRV_VEC_WIDTH-1:0]  vec_z,
    input  logic                                      out_valid,
    input  logic                                      out_stall,
    input  logic signed [qrv_pkg::QRV_VEC_WIDTH-1:0]  out_x,
    input  logic signed [qrv_pkg::QRV_VEC_WIDTH-1:0]  out_y,
    input  logic signed [qrv_pkg::QRV_VEC_WIDTH-1:0]  out_z,
    output int                                        mismatches,
    output int                                        pending
);

    localparam int     QW    = qrv_pkg::QRV_QUAT_WIDTH;
    localparam int     VW    = qrv_pkg::QRV_VEC_WIDTH;
    localparam int     FRAC  = QW - 1;
    localparam longint V_TOP = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint V_BOT = -V_TOP - 1;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } rot_vec_t;

    rot_vec_t expected_rot[$];

    function automatic longint round_shift(longint p, int s);
        return (p + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [VW-1:0] clamp_vec(longint t);
        if (t > V_TOP)
            return V_TOP[VW-1:0];
        if (t < V_BOT)
            return V_BOT[VW-1:0];
        return t[VW-1:0];
    endfunction

    function automatic rot_vec_t predict_rotation(
        logic                 inverse,
        logic signed [QW-1:0] qx,
        logic signed [QW-1:0] qy,
        logic signed [QW-1:0] qz,
        logic signed [QW-1:0] qw,
        logic signed [VW-1:0] vx,
        logic signed [VW-1:0] vy,
        logic signed [VW-1:0] vz
    );
        longint   q[3];
        longint   v2[3];
        longint   cr[3];
        longint   w;
        longint   w2;
        longint   dot;
        longint   t;
        longint   turn;
        longint   r[3];
        rot_vec_t res;
        int       j;
        int       k;
        q[0]  = longint'(qx);
        q[1]  = longint'(qy);
        q[2]  = longint'(qz);
        w     = longint'(qw);
        v2[0] = 2 * longint'(vx);
        v2[1] = 2 * longint'(vy);
        v2[2] = 2 * longint'(vz);
        w2    = w * w - (longint'(1) <<< (2 * FRAC - 1));
        dot   = 0;
        for (int i = 0; i < 3; i++)
            dot += round_shift(q[i] * v2[i], FRAC);
        for (int i = 0; i < 3; i++)
        begin
            j     = (i + 1) % 3;
            k     = (i + 2) % 3;
            cr[i] = round_shift(q[j] * v2[k], FRAC) - round_shift(q[k] * v2[j], FRAC);
        end
        for (int i = 0; i < 3; i++)
        begin
            turn = round_shift(cr[i] * w, FRAC);
            t    = round_shift(v2[i] * w2, 2 * FRAC);
            t    = inverse ? t - turn : t + turn;
            t   += round_shift(q[i] * dot, FRAC);
            r[i] = t;
        end
        res.x = clamp_vec(r[0]);
        res.y = clamp_vec(r[1]);
        res.z = clamp_vec(r[2]);
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        rot_vec_t exp_word;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rot.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d",
                             $time, out_x, out_y, out_z);
                end
                else
                begin
                    exp_word = expected_rot.pop_front();
                    if (out_x !== exp_word.x)
                    begin
                        mismatches++;
                        $display("%0t: out_x expected %0d got %0d", $time, exp_word.x, out_x);
                    end
                    if (out_y !== exp_word.y)
                    begin
                        mismatches++;
                        $display("%0t: out_y expected %0d got %0d", $time, exp_word.y, out_y);
                    end
                    if (out_z !== exp_word.z)
                    begin
                        mismatches++;
                        $display("%0t: out_z expected %0d got %0d", $time, exp_word.z, out_z);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_rot.push_back(predict_rotation(cmd, quat_x, quat_y, quat_z, quat_w,
                                                        vec_x, vec_y, vec_z));
            pending = expected_rot.size();
        end
    end

endmodule

// ----- dv/quaternion_rotate_vector_unit_test.sv -----
// Testbench top for the quaternion vector rotation unit: stimulus, flow control, verdict.
`timescale 1ns / 1ps

module quaternion_rotate_vector_unit_test;

    localparam int QW = qrv_pkg::QRV_QUAT_WIDTH;
    localparam int VW = qrv_pkg::QRV_VEC_WIDTH;

    localparam logic CMD_ROTATE  = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    localparam logic signed [QW-1:0] Q_ZERO     = '0;
    localparam logic signed [QW-1:0] Q_ONE      = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_NEG_ONE  = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] Q_HALF_RT2 = 16'sd23170;
    localparam logic signed [VW-1:0] V_ZERO     = '0;
    localparam logic signed [VW-1:0] V_UNIT     = 32'sd65536;
    localparam logic signed [VW-1:0] V_MAX      = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN      = {1'b1, {(VW-1){1'b0}}};

    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;

    int   mismatches;
    int   pending;
    int   cycles;
    logic long_hold;

    quaternion_rotate_vector_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z)
    );

    quaternion_rotate_vector_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .quat_w     (quat_w),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .vec_z      (vec_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_z      (out_z),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("quaternion_rotate_vector_unit_test NOT OK");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [QW-1:0] quat_edge();
        case ($urandom_range(0, 4))
            0: return Q_ONE;
            1: return Q_NEG_ONE;
            2: return Q_ZERO;
            3: return QW'(-1);
            default: return QW'(1);
        endcase
    endfunction

    function automatic logic signed [VW-1:0] random_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 4))
            0: return V_MAX;
            1: return V_MIN;
            2: return V_ZERO;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    task automatic random_quat(output logic signed [QW-1:0] qx, output logic signed [QW-1:0] qy,
                               output logic signed [QW-1:0] qz, output logic signed [QW-1:0] qw);
        int  r;
        real a0;
        real a1;
        real a2;
        real a3;
        real n;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            a0 = $itor($signed($urandom_range(0, 65534)) - 32767);
            a1 = $itor($signed($urandom_range(0, 65534)) - 32767);
            a2 = $itor($signed($urandom_range(0, 65534)) - 32767);
            a3 = $itor($signed($urandom_range(0, 65534)) - 32767);
            n  = $sqrt(a0 * a0 + a1 * a1 + a2 * a2 + a3 * a3);
            if (n < 1.0)
            begin
                a0 = 0.0;
                a1 = 0.0;
                a2 = 0.0;
                a3 = 1.0;
                n  = 1.0;
            end
            qx = QW'($rtoi(a0 / n * 32767.0));
            qy = QW'($rtoi(a1 / n * 32767.0));
            qz = QW'($rtoi(a2 / n * 32767.0));
            qw = QW'($rtoi(a3 / n * 32767.0));
        end
        else if (r < 85)
        begin
            qx = QW'($urandom);
            qy = QW'($urandom);
            qz = QW'($urandom);
            qw = QW'($urandom);
        end
        else
        begin
            qx = quat_edge();
            qy = quat_edge();
            qz = quat_edge();
            qw = quat_edge();
        end
    endtask

    task automatic send_item(input logic c,
                             input logic signed [QW-1:0] qx, input logic signed [QW-1:0] qy,
                             input logic signed [QW-1:0] qz, input logic signed [QW-1:0] qw,
                             input logic signed [VW-1:0] vx, input logic signed [VW-1:0] vy,
                             input logic signed [VW-1:0] vz, input int gap);
        @(negedge clk);
        in_valid = 1'b1;
        cmd      = c;
        quat_x   = qx;
        quat_y   = qy;
        quat_z   = qz;
        quat_w   = qw;
        vec_x    = vx;
        vec_y    = vy;
        vec_z    = vz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // receiver: random stalls, quiet stretches, and one long hold-off on request
    initial
    begin
        int stall_run;
        int quiet_run;
        int held;
        int r;
        out_stall = 1'b0;
        stall_run = 0;
        quiet_run = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall = 1'b1;
                held      = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
                out_stall = 1'b0;
            end
            else if (stall_run > 0)
            begin
                out_stall = 1'b1;
                stall_run--;
            end
            else if (quiet_run > 0)
            begin
                out_stall = 1'b0;
                quiet_run--;
            end
            else
            begin
                out_stall = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 6)
                    quiet_run = $urandom_range(20, 80);
                else if (r < 35)
                    stall_run = idle_len();
            end
        end
    end

    initial
    begin
        logic                 c;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        logic signed [QW-1:0] qw;
        int                   gap;
        rst_n     = 1'b0;
        long_hold = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_ROTATE;
        quat_x    = '0;
        quat_y    = '0;
        quat_z    = '0;
        quat_w    = '0;
        vec_x     = '0;
        vec_y     = '0;
        vec_z     = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        send_item(CMD_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, V_UNIT, 2 * V_UNIT, 3 * V_UNIT,
                  idle_len());
        send_item(CMD_INVERSE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, V_UNIT, 2 * V_UNIT, 3 * V_UNIT,
                  idle_len());
        send_item(CMD_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE, V_MAX, V_MIN, V_ZERO, 0);
        send_item(CMD_ROTATE, Q_NEG_ONE, Q_ZERO, Q_ZERO, Q_ZERO, V_MAX, V_MIN, -1, 0);
        send_item(CMD_INVERSE, Q_ZERO, Q_NEG_ONE, Q_ZERO, Q_ZERO, V_MAX, V_MIN, -1, idle_len());
        send_item(CMD_ROTATE, Q_ZERO, Q_ZERO, Q_NEG_ONE, Q_ZERO, V_MIN, V_MAX, 1, idle_len());
        send_item(CMD_ROTATE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, V_MAX, V_MAX, V_MAX, 0);
        send_item(CMD_INVERSE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, V_MIN, V_MIN, V_MIN, 0);
        send_item(CMD_ROTATE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, V_MAX, V_MAX, V_MAX, 0);
        send_item(CMD_INVERSE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, V_MIN, V_MIN, V_MIN, idle_len());
        send_item(CMD_ROTATE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, V_MAX, V_MIN, V_MAX, idle_len());
        send_item(CMD_INVERSE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, V_MIN, V_MAX, V_MIN, 0);
        send_item(CMD_ROTATE, Q_ZERO, Q_ZERO, Q_HALF_RT2, Q_HALF_RT2, V_UNIT, V_ZERO, V_ZERO, 0);
        send_item(CMD_INVERSE, Q_ZERO, Q_ZERO, Q_HALF_RT2, Q_HALF_RT2, V_UNIT, V_ZERO, V_ZERO,
                  idle_len());
        send_item(CMD_ROTATE, Q_HALF_RT2, Q_ZERO, Q_ZERO, Q_HALF_RT2, V_ZERO, V_UNIT, V_ZERO, 0);
        send_item(CMD_INVERSE, Q_ZERO, Q_HALF_RT2, Q_ZERO, Q_HALF_RT2, V_ZERO, V_ZERO, V_UNIT, 0);
        send_item(CMD_ROTATE, Q_ONE, Q_ONE, Q_ZERO, Q_ZERO, V_UNIT, -V_UNIT, V_UNIT, idle_len());
        send_item(CMD_ROTATE, QW'(-1), QW'(1), QW'(-1), QW'(1), 1, -1, 1, 0);
        send_item(CMD_INVERSE, 16'sd1234, -16'sd4321, 16'sd9876, 16'sd30000,
                  V_ZERO, V_ZERO, V_ZERO, 0);
        send_item(CMD_ROTATE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE, Q_ONE, V_MIN, V_MAX, V_MIN, idle_len());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // long output hold-off while words keep coming, then a full drain later on
            if (i == 150)
                long_hold = 1'b1;
            if (i == 151)
                long_hold = 1'b0;
            if (i == 500)
                wait_drained();
            if ((i % 100) < 20 || (i >= 150 && i < 230))
                gap = 0;
            else
                gap = idle_len();
            c = $urandom_range(0, 1) ? CMD_INVERSE : CMD_ROTATE;
            random_quat(qx, qy, qz, qw);
            send_item(c, qx, qy, qz, qw, random_coord(), random_coord(), random_coord(), gap);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("quaternion_rotate_vector_unit_test OK");
        else
            $display("quaternion_rotate_vector_unit_test NOT OK");
        $finish;
    end

endmodule
